// ===== rtl/core/odlr_pkg.sv =====
// overdub loop recorder package: sizes, configuration indexes, control structs
// and saturation helper; shared by the interfaces, controller, datapath and top
package odlr_pkg;

    localparam int LOOP_LENGTH = 262144;
    localparam int LOOP_AW     = $clog2(LOOP_LENGTH);

    localparam int SAMPLE_W   = 16;
    localparam int FADE_W     = 17;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;
    localparam int PROD_W     = SAMPLE_W + FADE_W + 1;
    localparam int SUM_W      = SAMPLE_W + 3;

    localparam logic [FADE_W-1:0] FULL_SCALE = FADE_W'(65536);
    localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(32768);

    localparam logic [CFG_IDX_W-1:0] CFG_GATE_MODE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIG_LOW     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIG_HIGH    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SLEW_STEP    = 2'd3;

    localparam logic                       GATE_MODE_RST = 1'b1;
    localparam logic signed [SAMPLE_W-1:0] TRIG_LOW_RST  = 16'sd0;
    localparam logic signed [SAMPLE_W-1:0] TRIG_HIGH_RST = 16'sd1024;
    localparam logic [FADE_W-1:0]          SLEW_RST      = 17'd205;

    typedef struct packed {
        logic capture;
        logic eval;
        logic sweep;
        logic mul;
        logic write;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic clear_fire;
        logic sweep_last;
    } status_t;

    function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [SUM_W-1:0] v);
        logic signed [SAMPLE_W-1:0] r;
        if (v > SUM_W'(32767))
            r = 16'sh7fff;
        else if (v < -SUM_W'(32768))
            r = -16'sh8000;
        else
            r = v[SAMPLE_W-1:0];
        return r;
    endfunction

endpackage

// ===== rtl/core/odlr_in_if.sv =====
// input channel of the loop recorder: valid/ready and one sample beat
// depends on odlr_pkg
interface odlr_in_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [odlr_pkg::SAMPLE_W-1:0] in_sample;
    logic signed [odlr_pkg::SAMPLE_W-1:0] gate_level;
    logic signed [odlr_pkg::SAMPLE_W-1:0] restart_level;
    logic signed [odlr_pkg::SAMPLE_W-1:0] clear_level;
    logic                                 monitor_pressed;

    modport source (
        output valid, in_sample, gate_level, restart_level, clear_level, monitor_pressed,
        input  ready
    );
    modport sink (
        input  valid, in_sample, gate_level, restart_level, clear_level, monitor_pressed,
        output ready
    );
endinterface

// ===== rtl/core/odlr_out_if.sv =====
// result channel of the loop recorder: valid/ready and one result beat
// depends on odlr_pkg
interface odlr_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [odlr_pkg::SAMPLE_W-1:0] out_sample;
    logic                                 recording;
    logic                                 monitor_active;

    modport source (
        output valid, out_sample, recording, monitor_active,
        input  ready
    );
    modport sink (
        input  valid, out_sample, recording, monitor_active,
        output ready
    );
endinterface

// ===== rtl/core/odlr_ctrl.sv =====
// loop recorder controller: sequences accept, evaluate, clear sweep, multiply,
// write-back and result hand-off; depends on odlr_pkg
module odlr_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  odlr_pkg::status_t  status,
    output odlr_pkg::cmd_t     cmd
);

    typedef enum logic [6:0] {
        ST_INIT  = 7'b0000001,
        ST_IDLE  = 7'b0000010,
        ST_EVAL  = 7'b0000100,
        ST_CLEAR = 7'b0001000,
        ST_MUL   = 7'b0010000,
        ST_WRITE = 7'b0100000,
        ST_HOLD  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_INIT:
            begin
                cmd.sweep = 1'b1;
                if (status.sweep_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                cmd.eval   = 1'b1;
                state_next = status.clear_fire ? ST_CLEAR : ST_MUL;
            end
            ST_CLEAR:
            begin
                cmd.sweep = 1'b1;
                if (status.sweep_last)
                    state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                cmd.write = 1'b1;
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
                else
                    state_next = ST_HOLD;
            end
            ST_HOLD:
            begin
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_accept_to_eval: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == ST_EVAL))
        else $error("accepted beat did not move to evaluation");

    a_load_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> out_free)
        else $error("result loaded over an untaken beat");

    a_valid_from_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(cmd.load_out))
        else $error("result valid without a load");

    a_one_mem_write: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.write && cmd.sweep))
        else $error("sweep and write-back collide");

endmodule

// ===== rtl/core/odlr_datapath.sv =====
// loop recorder datapath: configuration registers, triggers, crossfade slew,
// loop memory with clear sweep, overdub multiply and saturation; depends on odlr_pkg
module odlr_datapath (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wr_en,
    input  logic [odlr_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [odlr_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic signed [odlr_pkg::SAMPLE_W-1:0] in_sample,
    input  logic signed [odlr_pkg::SAMPLE_W-1:0] gate_level,
    input  logic signed [odlr_pkg::SAMPLE_W-1:0] restart_level,
    input  logic signed [odlr_pkg::SAMPLE_W-1:0] clear_level,
    input  logic                                 monitor_pressed,
    input  odlr_pkg::cmd_t                       cmd,
    output odlr_pkg::status_t                    status,
    output logic signed [odlr_pkg::SAMPLE_W-1:0] out_sample,
    output logic                                 recording,
    output logic                                 monitor_active
);

    localparam int SW = odlr_pkg::SAMPLE_W;
    localparam int FW = odlr_pkg::FADE_W;
    localparam int AW = odlr_pkg::LOOP_AW;
    localparam int PW = odlr_pkg::PROD_W;
    localparam int UW = odlr_pkg::SUM_W;
    localparam logic [AW-1:0] LAST_POS = AW'(odlr_pkg::LOOP_LENGTH - 1);

    // configuration
    logic                 gate_mode_reg;
    logic signed [SW-1:0] trig_low_reg;
    logic signed [SW-1:0] trig_high_reg;
    logic [FW-1:0]        slew_reg;

    // captured beat
    logic signed [SW-1:0] x_reg;
    logic signed [SW-1:0] gate_reg;
    logic signed [SW-1:0] restart_lvl_reg;
    logic signed [SW-1:0] clear_lvl_reg;
    logic                 pressed_reg;

    // loop state
    logic [AW-1:0] pos_reg, pos_next;
    logic [FW-1:0] fade_reg, fade_next;
    logic          restart_hi_reg, restart_hi_next;
    logic          clear_hi_reg, clear_hi_next;
    logic          btn_was_reg;
    logic          mon_reg, mon_next;
    logic          rec_reg, rec_next;
    logic [AW-1:0] sweep_cnt_reg;

    // working values
    logic signed [SW-1:0] mem [odlr_pkg::LOOP_LENGTH];
    logic signed [SW-1:0] rd_data_reg;
    logic signed [PW-1:0] prod_reg;
    logic signed [SW-1:0] out_sample_reg;
    logic                 recording_reg;
    logic                 monitor_active_reg;

    logic                 clear_fire;
    logic                 restart_fire;
    logic [AW-1:0]        rd_addr;
    logic [FW-1:0]        fade_target;
    logic [FW-1:0]        fade_diff;
    logic signed [PW-1:0] prod_rnd;
    logic signed [UW-1:0] dub;
    logic signed [UW-1:0] sum_wide;
    logic signed [SW-1:0] sum;
    logic signed [SW-1:0] out_val;

    // trigger evaluation
    always_comb
    begin
        clear_hi_next = clear_hi_reg;
        clear_fire    = 1'b0;
        if (clear_hi_reg)
        begin
            if (clear_lvl_reg <= trig_low_reg)
                clear_hi_next = 1'b0;
        end
        else if (clear_lvl_reg >= trig_high_reg)
        begin
            clear_hi_next = 1'b1;
            clear_fire    = 1'b1;
        end

        restart_hi_next = restart_hi_reg;
        restart_fire    = 1'b0;
        if (restart_hi_reg)
        begin
            if (restart_lvl_reg <= trig_low_reg)
                restart_hi_next = 1'b0;
        end
        else if (restart_lvl_reg >= trig_high_reg)
        begin
            restart_hi_next = 1'b1;
            restart_fire    = 1'b1;
        end
    end

    assign rd_addr  = restart_fire ? '0 : pos_reg;
    assign rec_next = gate_mode_reg ? (gate_reg > 0) : 1'b1;
    assign mon_next = (pressed_reg && !btn_was_reg) ? !mon_reg : mon_reg;

    // crossfade slew toward the gate
    assign fade_target = rec_next ? odlr_pkg::FULL_SCALE : '0;
    always_comb
    begin
        fade_next = fade_reg;
        fade_diff = '0;
        if (fade_reg < fade_target)
        begin
            fade_diff = fade_target - fade_reg;
            fade_next = (fade_diff > slew_reg) ? fade_reg + slew_reg : fade_target;
        end
        else if (fade_reg > fade_target)
        begin
            fade_diff = fade_reg - fade_target;
            fade_next = (fade_diff > slew_reg) ? fade_reg - slew_reg : fade_target;
        end
    end

    // overdub sum and monitor mix
    assign prod_rnd = prod_reg + odlr_pkg::ROUND_HALF;
    assign dub      = UW'($signed(prod_rnd[PW-1:16]));
    assign sum_wide = UW'(rd_data_reg) + dub;
    assign sum      = odlr_pkg::sat16(sum_wide);
    assign out_val  = (mon_reg && !rec_reg) ? odlr_pkg::sat16(UW'(sum) + UW'(x_reg)) : sum;

    always_comb
    begin
        pos_next = pos_reg;
        if (cmd.eval)
            pos_next = rd_addr;
        else if (cmd.write)
            pos_next = (pos_reg == LAST_POS) ? '0 : pos_reg + 1'b1;
    end

    assign status.clear_fire = clear_fire;
    assign status.sweep_last = (sweep_cnt_reg == LAST_POS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gate_mode_reg <= odlr_pkg::GATE_MODE_RST;
            trig_low_reg  <= odlr_pkg::TRIG_LOW_RST;
            trig_high_reg <= odlr_pkg::TRIG_HIGH_RST;
            slew_reg      <= odlr_pkg::SLEW_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                odlr_pkg::CFG_GATE_MODE: gate_mode_reg <= cfg_data[0];
                odlr_pkg::CFG_TRIG_LOW:  trig_low_reg  <= cfg_data[SW-1:0];
                odlr_pkg::CFG_TRIG_HIGH: trig_high_reg <= cfg_data[SW-1:0];
                odlr_pkg::CFG_SLEW_STEP: slew_reg      <= cfg_data[FW-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            fade_reg       <= '0;
            restart_hi_reg <= 1'b1;
            clear_hi_reg   <= 1'b1;
            btn_was_reg    <= 1'b1;
            mon_reg        <= 1'b0;
            rec_reg        <= 1'b0;
            sweep_cnt_reg  <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
            if (cmd.eval)
            begin
                fade_reg       <= fade_next;
                restart_hi_reg <= restart_hi_next;
                clear_hi_reg   <= clear_hi_next;
                btn_was_reg    <= pressed_reg;
                mon_reg        <= mon_next;
                rec_reg        <= rec_next;
            end
            if (cmd.sweep)
                sweep_cnt_reg <= (sweep_cnt_reg == LAST_POS) ? '0 : sweep_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            x_reg           <= in_sample;
            gate_reg        <= gate_level;
            restart_lvl_reg <= restart_level;
            clear_lvl_reg   <= clear_level;
            pressed_reg     <= monitor_pressed;
        end
        if (cmd.mul)
            prod_reg <= PW'(x_reg) * PW'($signed({1'b0, fade_reg}));
        if (cmd.load_out)
        begin
            out_sample_reg     <= out_val;
            recording_reg      <= rec_reg;
            monitor_active_reg <= mon_reg;
        end
    end

    // loop memory, one write port and one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.sweep)
            mem[sweep_cnt_reg] <= '0;
        else if (cmd.write)
            mem[pos_reg] <= sum;

        if (cmd.sweep)
            rd_data_reg <= '0;
        else if (cmd.eval)
            rd_data_reg <= mem[rd_addr];
    end

    assign out_sample     = out_sample_reg;
    assign recording      = recording_reg;
    assign monitor_active = monitor_active_reg;

    a_fade_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fade_reg <= odlr_pkg::FULL_SCALE)
        else $error("crossfade above full scale");

    a_restart_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.eval && restart_fire) |=> (pos_reg == '0))
        else $error("restart did not return position to start");

    a_sweep_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.sweep |-> (sweep_cnt_reg == '0))
        else $error("sweep counter left mid-way");

endmodule

// ===== rtl/core/overdub_loop_recorder.sv =====
// overdub loop recorder top level: joins the controller and datapath to the
// beat channels and the configuration port; depends on odlr_pkg and the interfaces
//
// Sound-on-sound looper over a 262144-sample loop memory. After reset the block
// runs a clearing pass over every entry of the memory before it takes its
// first beat; configuration writes are taken at any time. Each sample then goes
// through accept, evaluate triggers and read the loop memory, multiply by
// the crossfade, write back and load the output register. A clear trigger adds
// a sweep of every memory entry, one entry per cycle on its single write
// port, to that sample. A finished result waits in the output register while
// the next beat is accepted; while that result is not taken, the next sample
// holds the block after its own write-back until the output register is free.
module overdub_loop_recorder (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [odlr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [odlr_pkg::CFG_DATA_W-1:0]     cfg_data,
    odlr_in_if.sink                             audio,
    odlr_out_if.source                          result
);

    odlr_pkg::cmd_t    cmd;
    odlr_pkg::status_t status;

    odlr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (audio.valid),
        .in_ready  (audio.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .status    (status),
        .cmd       (cmd)
    );

    odlr_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_sample       (audio.in_sample),
        .gate_level      (audio.gate_level),
        .restart_level   (audio.restart_level),
        .clear_level     (audio.clear_level),
        .monitor_pressed (audio.monitor_pressed),
        .cmd             (cmd),
        .status          (status),
        .out_sample      (result.out_sample),
        .recording       (result.recording),
        .monitor_active  (result.monitor_active)
    );

endmodule
